>>> hw/rtl/hcr_pkg.sv
package hcr_pkg;

    localparam int PIX_W      = 8;
    localparam int GRAD_W     = 11;
    localparam int POS_W      = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIM_W      = 13;
    localparam int K_W        = 16;
    localparam int WT_W       = 16;
    localparam int SHIFT_W    = 6;
    localparam int RESP_W     = 32;
    localparam int MAX_ROWS   = 4096;
    localparam int MIN_DIM    = 8;

    localparam int SQ_W   = 2 * GRAD_W;
    localparam int W2_W   = 2 * WT_W;
    localparam int TERM_W = SQ_W + W2_W + 1;
    localparam int ACC_W  = 64;
    localparam int S_W    = 27;
    localparam int T_W    = S_W + 1;
    localparam int T2_W   = 2 * T_W;
    localparam int RES_W  = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_K      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_CENTER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_NEAR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_FAR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SHIFT  = 3'd6;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
    } grad_t;

    typedef struct packed {
        logic valid;
        logic emit;
        logic interior;
        logic last;
    } meta_t;

endpackage

>>> hw/rtl/harris_corner_response.sv
// Harris corner response over a raster stream of 8-bit gray pixels.
// Input channel: in_valid / in_stall with pixel, frame_start, drain; one item
// per pixel in raster order, frame_start on the first pixel of a frame, drain
// items push out pending results and count as black pixels.
// Output channel: out_valid / out_stall with response, on_border, frame_end;
// each item gives zero or one result, for the position REACH*(W+1) items back.
// Config: cfg_we writes cfg_data into register cfg_index; the user must write
// only while idle, as the block itself does not enforce it.
// Throughput: one item per clock unless a stall holds the pipeline; every
// stage and both line store ports (one read, one write each cycle) run at that
// rate. A result passes the Sobel, line store, square, weight, two adder tree,
// product, k-trace, subtract and shift/saturate stages to the output register.
// Stall: when a result waits in the output register and out_stall is high,
// the whole pipeline holds and in_stall is raised; nothing is lost or repeated.
// Reset: registers take their defaults, positions and windows clear, valid
// bits clear; line stores are not cleared and need no clearing pass.
module harris_corner_response
    import hcr_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    parameter int WINDOW    = 3
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [PIX_W-1:0]        pixel,
    input  logic                    frame_start,
    input  logic                    drain,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [RESP_W-1:0] response,
    output logic                    on_border,
    output logic                    frame_end
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int HALF   = WINDOW / 2;
    localparam int REACH  = HALF + 1;
    localparam logic [POS_W-1:0] ROW_CAP   = POS_W'(MAX_ROWS + REACH + 2);
    localparam logic [POS_W-1:0] MAX_W_POS = POS_W'(MAX_WIDTH);
    localparam logic [POS_W-1:0] MAX_H_POS = POS_W'(MAX_ROWS);
    localparam logic [POS_W-1:0] MIN_POS   = POS_W'(MIN_DIM);
    localparam logic signed [POS_W+1:0] REACH_S = (POS_W+2)'(REACH);
    localparam logic signed [POS_W+1:0] ONE_S   = (POS_W+2)'(1);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sd2147483648;
    localparam logic signed [RES_W-1:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [RES_W-1:0] SAT_MIN = -64'sd2147483648;

    typedef grad_t [WINDOW-2:0] gline_t;

    // configuration
    logic [DIM_W-1:0]   line_width_reg, line_count_reg;
    logic [K_W-1:0]     corner_k_reg;
    logic [WT_W-1:0]    weight_center_reg, weight_near_reg, weight_far_reg;
    logic [SHIFT_W-1:0] output_shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg    <= 13'd640;
            line_count_reg    <= 13'd480;
            corner_k_reg      <= 16'd2621;
            weight_center_reg <= 16'd34209;
            weight_near_reg   <= 16'd15663;
            weight_far_reg    <= 16'd0;
            output_shift_reg  <= 6'd17;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LINE_WIDTH:    line_width_reg    <= cfg_data[DIM_W-1:0];
                CFG_LINE_COUNT:    line_count_reg    <= cfg_data[DIM_W-1:0];
                CFG_CORNER_K:      corner_k_reg      <= cfg_data[K_W-1:0];
                CFG_WEIGHT_CENTER: weight_center_reg <= cfg_data[WT_W-1:0];
                CFG_WEIGHT_NEAR:   weight_near_reg   <= cfg_data[WT_W-1:0];
                CFG_WEIGHT_FAR:    weight_far_reg    <= cfg_data[WT_W-1:0];
                CFG_OUTPUT_SHIFT:  output_shift_reg  <= cfg_data[SHIFT_W-1:0];
                default:           ;
            endcase
        end
    end

    logic [POS_W-1:0] w_eff, h_eff;

    always_comb
    begin
        w_eff = {1'b0, line_width_reg};
        if (w_eff < MIN_POS)
            w_eff = MIN_POS;
        if (w_eff > MAX_W_POS)
            w_eff = MAX_W_POS;
        h_eff = {1'b0, line_count_reg};
        if (h_eff < MIN_POS)
            h_eff = MIN_POS;
        if (h_eff > MAX_H_POS)
            h_eff = MAX_H_POS;
    end

    // 2d weight table
    logic [WT_W-1:0] wt [WINDOW];
    logic [W2_W-1:0] w2_reg [WINDOW][WINDOW];

    always_comb
    begin
        for (int k = 0; k < WINDOW; k++)
        begin
            if (k == HALF)
                wt[k] = weight_center_reg;
            else if (k == HALF - 1 || k == HALF + 1)
                wt[k] = weight_near_reg;
            else
                wt[k] = weight_far_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < WINDOW; k++)
            for (int l = 0; l < WINDOW; l++)
                w2_reg[k][l] <= wt[k] * wt[l];
    end

    // pipeline control
    logic  out_valid_reg;
    logic  advance;
    logic  accept;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;
    assign accept   = in_valid && advance;

    // stage 0: position
    logic [POS_W-1:0]  col_pos_reg, row_pos_reg;
    logic [POS_W-1:0]  c0, r0, cn, rn;
    logic [ADDR_W-1:0] col0;

    always_comb
    begin
        c0 = frame_start ? '0 : col_pos_reg;
        r0 = frame_start ? '0 : row_pos_reg;
        if (c0 >= w_eff)
        begin
            c0 = '0;
            if (r0 < ROW_CAP)
                r0 = r0 + 1'b1;
        end
        col0 = c0[ADDR_W-1:0];
        cn = c0 + 1'b1;
        rn = r0;
        if (cn >= w_eff)
        begin
            cn = '0;
            if (rn < ROW_CAP)
                rn = rn + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else if (accept)
        begin
            col_pos_reg <= cn;
            row_pos_reg <= rn;
        end
    end

    // stage 1: pixel line store and sobel
    logic              v1_reg;
    logic [PIX_W-1:0]  px1_reg;
    logic [POS_W-1:0]  c1_reg, r1_reg;
    logic [ADDR_W-1:0] col1_reg;

    logic [2*PIX_W-1:0] pmem [MAX_WIDTH];
    logic [2*PIX_W-1:0] pmem_q_reg, pfwd_data_reg, pmem_eff, pmem_wdata;
    logic               pfwd_reg;
    logic               pmem_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (advance)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            px1_reg  <= drain ? '0 : pixel;
            c1_reg   <= c0;
            r1_reg   <= r0;
            col1_reg <= col0;
        end
    end

    assign pmem_eff   = pfwd_reg ? pfwd_data_reg : pmem_q_reg;
    assign pmem_wdata = {pmem_eff[PIX_W-1:0], px1_reg};
    assign pmem_we    = advance && v1_reg;

    always_ff @(posedge clk)
    begin
        if (pmem_we)
            pmem[col1_reg] <= pmem_wdata;
        if (advance)
        begin
            pmem_q_reg    <= pmem[col0];
            pfwd_reg      <= v1_reg && (col1_reg == col0);
            pfwd_data_reg <= pmem_wdata;
        end
    end

    logic [PIX_W-1:0] pw_reg [3][3];
    logic [PIX_W-1:0] pcol_new [3];
    logic [PIX_W+1:0] s_lft, s_rgt, s_top, s_bot;
    logic             g_live;
    grad_t            g1;

    assign pcol_new[0] = pmem_eff[2*PIX_W-1:PIX_W];
    assign pcol_new[1] = pmem_eff[PIX_W-1:0];
    assign pcol_new[2] = px1_reg;

    always_comb
    begin
        s_lft = {2'b0, pw_reg[0][1]} + {1'b0, pw_reg[1][1], 1'b0} + {2'b0, pw_reg[2][1]};
        s_rgt = {2'b0, pcol_new[0]} + {1'b0, pcol_new[1], 1'b0} + {2'b0, pcol_new[2]};
        s_top = {2'b0, pw_reg[0][1]} + {1'b0, pw_reg[0][2], 1'b0} + {2'b0, pcol_new[0]};
        s_bot = {2'b0, pw_reg[2][1]} + {1'b0, pw_reg[2][2], 1'b0} + {2'b0, pcol_new[2]};
        g_live = (c1_reg >= POS_W'(2)) && (r1_reg >= POS_W'(2))
                 && (r1_reg + 1'b1 <= h_eff);
        g1.gx = g_live ? $signed({1'b0, s_lft}) - $signed({1'b0, s_rgt}) : '0;
        g1.gy = g_live ? $signed({1'b0, s_top}) - $signed({1'b0, s_bot}) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
                for (int l = 0; l < 3; l++)
                    pw_reg[k][l] <= '0;
        end
        else if (pmem_we)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pw_reg[k][0] <= pw_reg[k][1];
                pw_reg[k][1] <= pw_reg[k][2];
                pw_reg[k][2] <= pcol_new[k];
            end
        end
    end

    // result position for this item
    logic signed [POS_W+1:0] ro, co, ws, hs;
    meta_t                   meta1;

    always_comb
    begin
        ws = $signed({2'b0, w_eff});
        hs = $signed({2'b0, h_eff});
        ro = $signed({2'b0, r1_reg}) - REACH_S;
        co = $signed({2'b0, c1_reg}) - REACH_S;
        if (co < 0)
        begin
            co = co + ws;
            ro = ro - ONE_S;
        end
        meta1.valid    = v1_reg;
        meta1.emit     = (ro >= 0) && (ro < hs);
        meta1.interior = (ro >= REACH_S) && (ro <= hs - ONE_S - REACH_S)
                         && (co >= REACH_S) && (co <= ws - ONE_S - REACH_S);
        meta1.last     = (ro == hs - ONE_S) && (co == ws - ONE_S);
    end

    // stage 2: gradient line store and window
    meta_t             meta2_reg;
    grad_t             g2_reg;
    logic [ADDR_W-1:0] col2_reg;

    gline_t gmem [MAX_WIDTH];
    gline_t gmem_q_reg, gfwd_data_reg, gmem_eff, gmem_wdata;
    logic   gfwd_reg;
    logic   gmem_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            meta2_reg <= '0;
        else if (advance)
            meta2_reg <= meta1;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            g2_reg   <= g1;
            col2_reg <= col1_reg;
        end
    end

    assign gmem_eff = gfwd_reg ? gfwd_data_reg : gmem_q_reg;
    assign gmem_we  = advance && meta2_reg.valid;

    always_comb
    begin
        for (int k = 0; k < WINDOW - 2; k++)
            gmem_wdata[k] = gmem_eff[k + 1];
        gmem_wdata[WINDOW-2] = g2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (gmem_we)
            gmem[col2_reg] <= gmem_wdata;
        if (advance)
        begin
            gmem_q_reg    <= gmem[col1_reg];
            gfwd_reg      <= meta2_reg.valid && (col2_reg == col1_reg);
            gfwd_data_reg <= gmem_wdata;
        end
    end

    grad_t gw_reg [WINDOW][WINDOW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WINDOW; k++)
                for (int l = 0; l < WINDOW; l++)
                    gw_reg[k][l] <= '0;
        end
        else if (gmem_we)
        begin
            for (int k = 0; k < WINDOW; k++)
                for (int l = 0; l < WINDOW - 1; l++)
                    gw_reg[k][l] <= gw_reg[k][l + 1];
            for (int k = 0; k < WINDOW - 1; k++)
                gw_reg[k][WINDOW-1] <= gmem_eff[k];
            gw_reg[WINDOW-1][WINDOW-1] <= g2_reg;
        end
    end

    // stages 3..10: metadata travels with the arithmetic
    meta_t meta_reg [3:10];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 3; i <= 10; i++)
                meta_reg[i] <= '0;
        end
        else if (advance)
        begin
            meta_reg[3] <= meta2_reg;
            for (int i = 4; i <= 10; i++)
                meta_reg[i] <= meta_reg[i - 1];
        end
    end

    // stage 3 -> 4: products of gradients (0 xx, 1 xy, 2 yy)
    logic signed [SQ_W-1:0]   sq_reg   [3][WINDOW][WINDOW];
    logic signed [TERM_W-1:0] term_reg [3][WINDOW][WINDOW];
    logic signed [ACC_W-1:0]  row_reg  [3][WINDOW];
    logic signed [ACC_W-1:0]  acc_reg  [3];
    logic signed [ACC_W-1:0]  row_next [3][WINDOW];
    logic signed [ACC_W-1:0]  acc_next [3];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < WINDOW; k++)
                for (int l = 0; l < WINDOW; l++)
                begin
                    sq_reg[0][k][l] <= gw_reg[k][l].gx * gw_reg[k][l].gx;
                    sq_reg[1][k][l] <= gw_reg[k][l].gx * gw_reg[k][l].gy;
                    sq_reg[2][k][l] <= gw_reg[k][l].gy * gw_reg[k][l].gy;
                end
        end
    end

    // stage 4 -> 5: gaussian weighting
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int q = 0; q < 3; q++)
                for (int k = 0; k < WINDOW; k++)
                    for (int l = 0; l < WINDOW; l++)
                        term_reg[q][k][l] <= $signed({1'b0, w2_reg[k][l]}) * sq_reg[q][k][l];
        end
    end

    // stage 5 -> 6: row sums, stage 6 -> 7: total with rounding
    always_comb
    begin
        for (int q = 0; q < 3; q++)
        begin
            for (int k = 0; k < WINDOW; k++)
            begin
                row_next[q][k] = '0;
                for (int l = 0; l < WINDOW; l++)
                    row_next[q][k] = row_next[q][k] + ACC_W'(term_reg[q][k][l]);
            end
            acc_next[q] = ROUND_HALF;
            for (int k = 0; k < WINDOW; k++)
                acc_next[q] = acc_next[q] + row_reg[q][k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int q = 0; q < 3; q++)
            begin
                for (int k = 0; k < WINDOW; k++)
                    row_reg[q][k] <= row_next[q][k];
                acc_reg[q] <= acc_next[q];
            end
        end
    end

    // stage 7 -> 8: determinant products and trace squared
    logic signed [S_W-1:0]   sxx, sxy, syy;
    logic [T_W-1:0]          tr;
    logic signed [2*S_W-1:0] pa_reg, pb_reg;
    logic [T2_W-1:0]         t2_reg;

    assign sxx = acc_reg[0][32 +: S_W];
    assign sxy = acc_reg[1][32 +: S_W];
    assign syy = acc_reg[2][32 +: S_W];
    assign tr  = T_W'(unsigned'(sxx)) + T_W'(unsigned'(syy));

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pa_reg <= sxx * syy;
            pb_reg <= sxy * sxy;
            t2_reg <= tr * tr;
        end
    end

    // stage 8 -> 9: det and k * trace^2 in two partial products
    logic signed [RES_W-1:0]   det_reg, diff_reg;
    logic [T2_W-16+K_W-1:0]    kth_reg;
    logic [K_W-1:0]            ktl_reg;
    logic [K_W+16-1:0]         ktl_full;

    assign ktl_full = corner_k_reg * t2_reg[15:0];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            det_reg <= RES_W'(pa_reg) - RES_W'(pb_reg);
            kth_reg <= corner_k_reg * t2_reg[T2_W-1:16];
            ktl_reg <= ktl_full[K_W+16-1:16];
        end
    end

    // stage 9 -> 10: response before scaling
    always_ff @(posedge clk)
    begin
        if (advance)
            diff_reg <= det_reg - $signed(RES_W'(kth_reg)) - $signed(RES_W'(ktl_reg));
    end

    // stage 10 -> output: shift and saturate
    logic signed [RES_W-1:0]  shifted;
    logic signed [RESP_W-1:0] sat_next;
    logic signed [RESP_W-1:0] response_reg;
    logic                     on_border_reg, frame_end_reg;

    always_comb
    begin
        shifted = diff_reg >>> output_shift_reg;
        if (shifted > SAT_MAX)
            sat_next = SAT_MAX[RESP_W-1:0];
        else if (shifted < SAT_MIN)
            sat_next = SAT_MIN[RESP_W-1:0];
        else
            sat_next = shifted[RESP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= meta_reg[10].valid && meta_reg[10].emit;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            response_reg  <= meta_reg[10].interior ? sat_next : '0;
            on_border_reg <= !meta_reg[10].interior;
            frame_end_reg <= meta_reg[10].last;
        end
    end

    assign out_valid = out_valid_reg;
    assign response  = response_reg;
    assign on_border = on_border_reg;
    assign frame_end = frame_end_reg;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import hcr_pkg::*;

    localparam int MAXW         = 4096;
    localparam int REACH        = 2;
    localparam int ROW_CAP      = MAX_ROWS + REACH + 2;
    localparam int LATENCY      = 11;
    localparam int SETTLE       = 3 * LATENCY;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 1150;

    typedef struct {
        logic signed [RESP_W-1:0] response;
        logic                     on_border;
        logic                     frame_end;
    } corner_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [PIX_W-1:0]         pixel;
    logic                     frame_start;
    logic                     drain;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [RESP_W-1:0] response;
    logic                     on_border;
    logic                     frame_end;

    harris_corner_response dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel      (pixel),
        .frame_start(frame_start),
        .drain      (drain),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .response   (response),
        .on_border  (on_border),
        .frame_end  (frame_end)
    );

    // predictor state
    int          line_w, line_h;
    logic [15:0] k_q, wt_center, wt_near, wt_far;
    logic [5:0]  resp_shift;
    logic [7:0]  pix_rows [2*MAXW];
    int          gx_rows [2*MAXW];
    int          gy_rows [2*MAXW];
    logic [7:0]  pix_win [3][3];
    int          gx_win [3][3];
    int          gy_win [3][3];
    int          col_pos, row_pos;

    corner_t pending_corners[$];
    int      errors;
    int      items_sent;
    int      quiet;
    bit      calm;
    bit      hold_req;

    always #10 clk = ~clk;

    function automatic int width_eff();
        return line_w < MIN_DIM ? MIN_DIM : (line_w > MAXW ? MAXW : line_w);
    endfunction

    function automatic int height_eff();
        return line_h < MIN_DIM ? MIN_DIM : (line_h > MAX_ROWS ? MAX_ROWS : line_h);
    endfunction

    function automatic logic signed [RESP_W-1:0] corner_strength();
        longint wt[3];
        longint axx, axy, ayy, w2, gx, gy, sxx, sxy, syy, det, kt, res;
        longint unsigned tr, t2, kk;
        longint half;
        half = 64'sd2147483648;
        axx = 0;
        axy = 0;
        ayy = 0;
        wt[0] = wt_near;
        wt[1] = wt_center;
        wt[2] = wt_near;
        for (int k = 0; k < 3; k++)
            for (int l = 0; l < 3; l++)
            begin
                w2 = wt[k] * wt[l];
                gx = gx_win[k][l];
                gy = gy_win[k][l];
                axx += w2 * (gx * gx);
                axy += w2 * (gx * gy);
                ayy += w2 * (gy * gy);
            end
        sxx = (axx + half) >>> 32;
        sxy = (axy + half) >>> 32;
        syy = (ayy + half) >>> 32;
        det = sxx * syy - sxy * sxy;
        tr = sxx + syy;
        t2 = tr * tr;
        kk = k_q;
        kt = kk * (t2 >> 16) + ((kk * (t2 & 64'hFFFF)) >> 16);
        res = (det - kt) >>> resp_shift;
        if (res > 64'sd2147483647)
            res = 64'sd2147483647;
        if (res < -64'sd2147483648)
            res = -64'sd2147483648;
        return res[31:0];
    endfunction

    function automatic void predict_pixel(logic [7:0] pin, logic fs, logic dr);
        int w, h, c, r, col, ro, co, lft, rgt, top, bot, gx, gy;
        logic [7:0] px;
        corner_t e;
        bit interior;
        w = width_eff();
        h = height_eff();
        c = col_pos;
        r = row_pos;
        px = dr ? 8'd0 : pin;
        gx = 0;
        gy = 0;
        if (fs)
        begin
            c = 0;
            r = 0;
        end
        if (c >= w)
        begin
            c = 0;
            if (r < ROW_CAP)
                r++;
        end
        col = c & (MAXW - 1);
        for (int k = 0; k < 3; k++)
        begin
            pix_win[k][0] = pix_win[k][1];
            pix_win[k][1] = pix_win[k][2];
        end
        pix_win[0][2] = pix_rows[col];
        pix_win[1][2] = pix_rows[MAXW + col];
        pix_win[2][2] = px;
        pix_rows[col] = pix_rows[MAXW + col];
        pix_rows[MAXW + col] = px;
        if (c >= 2 && r >= 2 && r - 1 <= h - 2)
        begin
            lft = pix_win[0][0] + 2 * pix_win[1][0] + pix_win[2][0];
            rgt = pix_win[0][2] + 2 * pix_win[1][2] + pix_win[2][2];
            top = pix_win[0][0] + 2 * pix_win[0][1] + pix_win[0][2];
            bot = pix_win[2][0] + 2 * pix_win[2][1] + pix_win[2][2];
            gx = lft - rgt;
            gy = top - bot;
        end
        for (int k = 0; k < 3; k++)
        begin
            gx_win[k][0] = gx_win[k][1];
            gx_win[k][1] = gx_win[k][2];
            gy_win[k][0] = gy_win[k][1];
            gy_win[k][1] = gy_win[k][2];
        end
        gx_win[0][2] = gx_rows[col];
        gx_win[1][2] = gx_rows[MAXW + col];
        gx_win[2][2] = gx;
        gy_win[0][2] = gy_rows[col];
        gy_win[1][2] = gy_rows[MAXW + col];
        gy_win[2][2] = gy;
        gx_rows[col] = gx_rows[MAXW + col];
        gx_rows[MAXW + col] = gx;
        gy_rows[col] = gy_rows[MAXW + col];
        gy_rows[MAXW + col] = gy;
        ro = r - REACH;
        co = c - REACH;
        if (co < 0)
        begin
            co += w;
            ro -= 1;
        end
        if (ro >= 0 && ro < h)
        begin
            interior = ro >= REACH && ro <= h - 1 - REACH && co >= REACH && co <= w - 1 - REACH;
            e.response = interior ? corner_strength() : '0;
            e.on_border = !interior;
            e.frame_end = (ro == h - 1 && co == w - 1);
            pending_corners.push_back(e);
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            if (r < ROW_CAP)
                r++;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    task automatic flag_mismatch(string what);
        $display("error at %0t: %s", $realtime, what);
        errors++;
    endtask

    // result checker and watchdog
    always @(negedge clk)
    begin
        corner_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_corners.size() == 0)
                flag_mismatch("result with nothing expected");
            else
            begin
                e = pending_corners.pop_front();
                if (response !== e.response)
                    flag_mismatch($sformatf("response %0d, expected %0d", response, e.response));
                if (on_border !== e.on_border)
                    flag_mismatch($sformatf("on_border %b, expected %b", on_border, e.on_border));
                if (frame_end !== e.frame_end)
                    flag_mismatch($sformatf("frame_end %b, expected %b", frame_end, e.frame_end));
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet = 0;
        else if (++quiet >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // output stall bursts and the long hold-off
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic offer_pixel(logic [7:0] p, logic fs, logic dr);
        bit st;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel <= p;
        frame_start <= fs;
        drain <= dr;
        forever
        begin
            @(negedge clk);
            st = in_stall;
            @(posedge clk);
            if (!st)
                break;
        end
        predict_pixel(p, fs, dr);
        items_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_corners.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LINE_WIDTH:    line_w = val & 16'h1FFF;
            CFG_LINE_COUNT:    line_h = val & 16'h1FFF;
            CFG_CORNER_K:      k_q = val;
            CFG_WEIGHT_CENTER: wt_center = val;
            CFG_WEIGHT_NEAR:   wt_near = val;
            CFG_WEIGHT_FAR:    wt_far = val;
            CFG_OUTPUT_SHIFT:  resp_shift = val[5:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(int w, int h, int k, int wc, int wn, int wf, int sh);
        settle();
        set_reg(CFG_LINE_WIDTH, 16'(w));
        set_reg(CFG_LINE_COUNT, 16'(h));
        set_reg(CFG_CORNER_K, 16'(k));
        set_reg(CFG_WEIGHT_CENTER, 16'(wc));
        set_reg(CFG_WEIGHT_NEAR, 16'(wn));
        set_reg(CFG_WEIGHT_FAR, 16'(wf));
        set_reg(CFG_OUTPUT_SHIFT, 16'(sh));
    endtask

    function automatic logic [7:0] pick_pixel(int mode, int x, int y, int bx, int by,
                                              logic [7:0] lo, logic [7:0] hi);
        case (mode)
            0: return 8'($urandom_range(0, 255));
            1: return (x >= bx && y >= by) ? hi : lo;
            2: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: return 8'(x * lo + y * hi);
        endcase
    endfunction

    // one frame in raster order, then drain items to flush it; a broken frame
    // restarts, drains early, stops early or lacks its frame start
    task automatic send_frame(int mode, logic [7:0] lo, logic [7:0] hi, bit broken);
        int w, h, n, bx, by, cut, kind;
        logic [7:0] p;
        w = width_eff();
        h = height_eff();
        n = w * h;
        bx = $urandom_range(1, w - 2);
        by = $urandom_range(1, h - 2);
        cut = broken ? $urandom_range(1, n - 1) : n;
        kind = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
        begin
            p = pick_pixel(mode, i % w, i / w, bx, by, lo, hi);
            if (i == cut && kind == 0)
                offer_pixel(p, 1'b1, 1'b0);
            else if (i == cut && kind == 1)
                repeat ($urandom_range(1, 2 * w)) offer_pixel(8'($urandom), 1'b0, 1'b1);
            else if (i == cut && kind == 2)
                break;
            if (!(i == cut && kind == 0))
                offer_pixel(p, i == 0 && !(broken && kind == 3), 1'b0);
        end
        repeat (2 * (w + 1) + $urandom_range(0, 3)) offer_pixel(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic test_directed();
        // a few items at the default 640-wide setting, then restart on a tiny frame
        offer_pixel(8'd0, 1'b1, 1'b0);
        offer_pixel(8'd255, 1'b0, 1'b0);
        offer_pixel(8'd255, 1'b0, 1'b1);
        configure(8, 8, 2621, 34209, 15663, 0, 17);
        send_frame(1, 8'd0, 8'd255, 1'b0);
        send_frame(2, 8'd0, 8'd255, 1'b1);
    endtask

    task automatic test_register_extremes();
        configure(0, 0, 0, 0, 0, 0, 0);
        send_frame(0, 8'd0, 8'd0, 1'b0);
        configure(7, 3, 65535, 65535, 65535, 65535, 63);
        send_frame(2, 8'd0, 8'd255, 1'b0);
        configure(8, 8, 65535, 65535, 65535, 0, 0);
        send_frame(1, 8'd255, 8'd0, 1'b0);
        configure(13, 9, 0, 65535, 0, 65535, 0);
        send_frame(3, 8'd37, 8'd91, 1'b0);
        configure(9, 11, 1, 20000, 40000, 12345, 31);
        send_frame(0, 8'd0, 8'd0, 1'b0);
    endtask

    task automatic test_random_frames();
        while (items_sent < RANDOM_ITEMS)
        begin
            configure($urandom_range(8, 20), $urandom_range(8, 12),
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : 2621,
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 40));
            repeat ($urandom_range(1, 3))
                send_frame($urandom_range(0, 3), 8'($urandom), 8'($urandom),
                           $urandom_range(0, 6) == 0);
        end
    endtask

    task automatic test_backpressure();
        configure(16, 10, 2621, 34209, 15663, 0, 12);
        hold_req = 1'b1;
        send_frame(0, 8'd0, 8'd0, 1'b0);
    endtask

    // only the start of row 0 at the widest setting, the first rows at the tallest
    task automatic test_large_frames();
        configure(8191, 8, 2621, 34209, 15663, 0, 17);
        offer_pixel(8'd10, 1'b1, 1'b0);
        repeat (99) offer_pixel(8'($urandom), 1'b0, 1'b0);
        configure(8, 8191, 2621, 34209, 15663, 0, 17);
        offer_pixel(8'd200, 1'b1, 1'b0);
        repeat (127) offer_pixel(8'($urandom), 1'b0, 1'b0);
    endtask

    task automatic test_steady_stream();
        calm = 1'b1;
        configure(12, 9, 3000, 40000, 12000, 0, 10);
        send_frame(0, 8'd0, 8'd0, 1'b0);
        send_frame(1, 8'd0, 8'd255, 1'b0);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_LINE_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        pixel = '0;
        frame_start = 1'b0;
        drain = 1'b0;
        errors = 0;
        items_sent = 0;
        quiet = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        line_w = 640;
        line_h = 480;
        k_q = 16'd2621;
        wt_center = 16'd34209;
        wt_near = 16'd15663;
        wt_far = 16'd0;
        resp_shift = 6'd17;
        col_pos = 0;
        row_pos = 0;
        for (int i = 0; i < 2 * MAXW; i++)
        begin
            pix_rows[i] = '0;
            gx_rows[i] = 0;
            gy_rows[i] = 0;
        end
        for (int k = 0; k < 3; k++)
            for (int l = 0; l < 3; l++)
            begin
                pix_win[k][l] = '0;
                gx_win[k][l] = 0;
                gy_win[k][l] = 0;
            end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_extremes();
        test_random_frames();
        test_backpressure();
        test_large_frames();
        test_steady_stream();

        settle();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/hcr_pkg.sv
hw/rtl/harris_corner_response.sv
tb/sv/tb.sv
